[src/length_prefixed_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed deframer
// Shared clocked property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Property checked at every edge outside reset.
`define LPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Types, codes and defaults shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int LPD_LENGTH_BYTES   = 4;
   localparam int LPD_GREETING_BYTES = 8;

   localparam logic [63:0] GREETING_RESET = 64'h4F4D_4547_4152_5047;

   localparam logic [1:0] EV_PAYLOAD  = 2'd0;
   localparam logic [1:0] EV_GREET_OK = 2'd1;
   localparam logic [1:0] EV_MISMATCH = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } lpd_item_type;

endpackage

[src/lpd_in_reg.sv]
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module lpd_in_reg
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         take,
   output lpd_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept ? 1'b1 : (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_rx_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

[src/lpd_core.sv]
// ----------------------------------------------------------------------------
// Deframer core
// Greeting check, length assembly and payload count, with the result register.
// ----------------------------------------------------------------------------
module lpd_core
   import lpd_pkg::*;
#(
   parameter int LENGTH_BYTES   = LPD_LENGTH_BYTES,
   parameter int GREETING_BYTES = LPD_GREETING_BYTES
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [63:0]  csr_wr_data,
   input  lpd_item_type item,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_event_kind,
   output logic [7:0]   rsp_payload_byte,
   output logic         rsp_frame_last
);

   localparam int LEN_W  = 8 * LENGTH_BYTES;
   localparam int GCNT_W = (GREETING_BYTES > 1) ? $clog2(GREETING_BYTES) : 1;
   localparam int LCNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

   localparam logic [1:0] PH_GREET = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_DATA  = 2'd2;
   localparam logic [1:0] PH_HALT  = 2'd3;

   logic [63:0]       greeting_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [GCNT_W-1:0] greet_cnt_ff, greet_cnt_in;
   logic [LCNT_W-1:0] len_cnt_ff, len_cnt_in;
   logic [LEN_W-1:0]  len_shift_ff, len_shift_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              match_ff, match_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;

   logic              consume;
   logic              emit;
   logic [63:0]       greet_shifted;
   logic [7:0]        expect_byte;
   logic              match_now;
   logic [LEN_W+7:0]  len_wide;
   logic [LEN_W-1:0]  len_next;

   assign take    = !rsp_valid_ff || !rsp_stall;
   assign consume = item.valid && take;

   assign greet_shifted = greeting_ff << {greet_cnt_ff, 3'b000};
   assign expect_byte   = greet_shifted[63:56];
   assign match_now     = match_ff && (item.data == expect_byte);
   assign len_wide      = {len_shift_ff, item.data};
   assign len_next      = len_wide[LEN_W-1:0];

   always_comb begin
      phase_in     = phase_ff;
      greet_cnt_in = greet_cnt_ff;
      len_cnt_in   = len_cnt_ff;
      len_shift_in = len_shift_ff;
      remain_in    = remain_ff;
      match_in     = match_ff;
      emit         = 1'b0;
      kind_in      = EV_PAYLOAD;
      byte_in      = 8'd0;
      last_in      = 1'b0;
      unique case (phase_ff)
         PH_GREET: begin
            if (greet_cnt_ff == GCNT_W'(GREETING_BYTES - 1)) begin
               greet_cnt_in = '0;
               len_cnt_in   = '0;
               len_shift_in = '0;
               match_in     = match_now;
               emit         = 1'b1;
               if (match_now) begin
                  phase_in = PH_LEN;
                  kind_in  = EV_GREET_OK;
               end else begin
                  phase_in = PH_HALT;
                  kind_in  = EV_MISMATCH;
               end
            end else begin
               greet_cnt_in = greet_cnt_ff + 1'b1;
               match_in     = match_now;
            end
         end
         PH_LEN: begin
            if (len_cnt_ff == LCNT_W'(LENGTH_BYTES - 1)) begin
               len_cnt_in   = '0;
               len_shift_in = '0;
               if (len_next != '0) begin
                  remain_in = len_next;
                  phase_in  = PH_DATA;
               end
            end else begin
               len_cnt_in   = len_cnt_ff + 1'b1;
               len_shift_in = len_next;
            end
         end
         PH_DATA: begin
            remain_in = remain_ff - 1'b1;
            emit      = 1'b1;
            kind_in   = EV_PAYLOAD;
            byte_in   = item.data;
            last_in   = (remain_ff == LEN_W'(1));
            if (last_in) begin
               phase_in     = PH_LEN;
               len_shift_in = '0;
            end
         end
         PH_HALT: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = consume ? emit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         greeting_ff  <= GREETING_RESET;
         phase_ff     <= PH_GREET;
         greet_cnt_ff <= '0;
         len_cnt_ff   <= '0;
         len_shift_ff <= '0;
         remain_ff    <= '0;
         match_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            greeting_ff <= csr_wr_data;
         end
         if (consume) begin
            phase_ff     <= phase_in;
            greet_cnt_ff <= greet_cnt_in;
            len_cnt_ff   <= len_cnt_in;
            len_shift_ff <= len_shift_in;
            remain_ff    <= remain_in;
            match_ff     <= match_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_frame_last   = last_ff;

endmodule

[src/length_prefixed_deframer.sv]
// ----------------------------------------------------------------------------
// Length-prefixed deframer
// Receive-side deframer for a byte link with a greeting and length prefixes.
// ----------------------------------------------------------------------------
// The request channel carries one received byte per request on req_rx_byte.
// The first GREETING_BYTES bytes are compared with the greeting register,
// and the last of them gives a greeting-accepted or a mismatch event. After
// a mismatch the link halts and every byte is dropped until reset. After an
// accepted greeting each frame is LENGTH_BYTES length bytes, most significant
// first, and then that many payload bytes, each given out on the rsp_ channel
// with rsp_frame_last set on the final one. Length bytes and zero-length
// frames give no response.
// A request is taken into an input register and, when the core consumes it,
// its response, if it has one, is registered in the output register, where
// it holds until it is taken. One request is accepted every cycle while
// req_stall is low; the input register and the output register each hold
// one byte.
// Reset clears the state to the greeting phase and restores the greeting
// register. While rsp_stall is high the response holds and req_stall rises
// once the input register is also occupied. The user must write the greeting
// register through csr_wr_en only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module length_prefixed_deframer
   import lpd_pkg::*;
#(
   parameter int LENGTH_BYTES   = LPD_LENGTH_BYTES,
   parameter int GREETING_BYTES = LPD_GREETING_BYTES
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last
);

   lpd_item_type item;
   logic         take;

   lpd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .item        (item)
   );

   lpd_core #(
      .LENGTH_BYTES   (LENGTH_BYTES),
      .GREETING_BYTES (GREETING_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .item             (item),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

[src/lpd_checker.sv]
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks the response behavior seen at the deframer ports.
// ----------------------------------------------------------------------------
`include "length_prefixed_deframer_assert.svh"

module lpd_checker
   import lpd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_frame_last
);

   `LPD_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_frame_last),
      "Stalled response changed.")
   `LPD_ASSERT(a_greet_clean, clock, reset,
      rsp_valid && (rsp_event_kind != EV_PAYLOAD)
         |-> (rsp_payload_byte == 8'd0) && !rsp_frame_last,
      "Greeting event carries data.")
   `LPD_ASSERT(a_halt_silent, clock, reset,
      rsp_valid && !rsp_stall && (rsp_event_kind == EV_MISMATCH) |=> !rsp_valid,
      "Response after greeting mismatch.")
   `LPD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid,
      "Response valid right after reset.")

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_last   (rsp_frame_last)
);
